[hdl/prsm_pkg.sv]
// Shared widths, constants, register indexes and types of the packet rate and sequence monitor.
package prsm_pkg;

    // Field widths
    localparam int LEN_W      = 16;
    localparam int TIME_W     = 48;
    localparam int SEQ_W      = 16;
    localparam int WIN_W      = 32;
    localparam int BYTES_W    = 32;
    localparam int SUM_W      = 40;
    localparam int COUNT_W    = 32;
    localparam int MBPS_W     = 16;
    localparam int KBPS_W     = 10;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Bit-serial divider geometry
    localparam int DIV_DVD_W  = 40;
    localparam int DIV_DSR_W  = 32;
    localparam int DIV_STEPS  = DIV_DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Rate conversion: bytes to bits is a shift, then two divides by one thousand
    localparam int BYTE_SHIFT    = 3;
    localparam int BITS_PER_KBIT = 1000;

    // Register reset values
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = '1;
    localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(1000000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_EN  = 2'd2;

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CALC   = 7'b0000010,
        S_UPDATE = 7'b0000100,
        S_DIV1   = 7'b0001000,
        S_DIV2   = 7'b0010000,
        S_COMMIT = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[hdl/packet_rate_and_sequence_monitor.sv]
// Packet rate and sequence monitor: top level with sequencer, state and output register.
//
// Usage: each input word carries one received packet (packet_length,
// arrival_time_us, seq_number) on in_valid/in_stall; each output word carries
// exactly one result on out_valid/out_stall. A word moves on a clock edge
// with valid high and stall low. Configuration registers (max packet length, window
// length, sequence check enable) are written through cfg_write_enable, cfg_index and
// cfg_data, by the user only while the block is idle; the block does not enforce it.
// Throughput: one packet at a time. An ordinary packet passes the calculate,
// update, commit and output states to the output register, and the next
// packet can be accepted in the cycle after. A packet that closes a window
// also takes two passes of a 40-step bit-serial divider (mean interval and
// bits per thousand in parallel, then thousands per thousand) between the
// update and commit states.
// Stall: the finished result waits in the output register; the block takes a
// new packet meanwhile and holds its next result until the register is free.
// Reset: all totals and timestamps clear, registers return to their defaults
// and no result is pending.
module packet_rate_and_sequence_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                cfg_write_enable,
    input  logic [prsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input packet words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [prsm_pkg::LEN_W-1:0]          packet_length,
    input  logic [prsm_pkg::TIME_W-1:0]         arrival_time_us,
    input  logic [prsm_pkg::SEQ_W-1:0]          seq_number,
    // Result words
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                oversize,
    output logic                                report_valid,
    output logic [prsm_pkg::MBPS_W-1:0]         rate_mbps,
    output logic [prsm_pkg::KBPS_W-1:0]         rate_kbps_fraction,
    output logic [prsm_pkg::SUM_W-1:0]          mean_interval_us,
    output logic                                seq_error,
    output logic [prsm_pkg::COUNT_W-1:0]        error_count,
    output logic [prsm_pkg::COUNT_W-1:0]        check_count
);
    import prsm_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0]   max_len_reg, max_len_next;
    logic [WIN_W-1:0]   window_reg, window_next;
    logic               seq_en_reg, seq_en_next;

    // Sequencer
    state_t             state_reg, state_next;

    // Captured input word
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;

    // Monitor state
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [TIME_W-1:0]  last_reg, last_next;
    logic [SEQ_W-1:0]   prev_seq_reg, prev_seq_next;
    logic [COUNT_W-1:0] checks_reg, checks_next;
    logic [COUNT_W-1:0] gaps_reg, gaps_next;

    // Per-packet working results
    logic [TIME_W-1:0]  interval_reg, interval_next;
    logic               over_reg, over_next;
    logic               rep_reg, rep_next;
    logic               serr_reg, serr_next;
    logic [SUM_W-1:0]   mean_reg, mean_next;
    logic [MBPS_W-1:0]  mbps_reg, mbps_next;
    logic [KBPS_W-1:0]  kbps_reg, kbps_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_over_reg, out_over_next;
    logic               out_rep_reg, out_rep_next;
    logic [MBPS_W-1:0]  out_mbps_reg, out_mbps_next;
    logic [KBPS_W-1:0]  out_kbps_reg, out_kbps_next;
    logic [SUM_W-1:0]   out_mean_reg, out_mean_next;
    logic               out_serr_reg, out_serr_next;
    logic [COUNT_W-1:0] out_gaps_reg, out_gaps_next;
    logic [COUNT_W-1:0] out_checks_reg, out_checks_next;

    // Combinational helpers
    logic               in_accept;
    logic               out_free;
    logic [BYTES_W:0]   bytes_sum;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W:0]    sum_wide;
    logic [COUNT_W-1:0] checks_inc;
    logic               gap;

    // Divider hookup
    logic                   mean_start;
    logic                   rate_start;
    logic [DIV_DVD_W-1:0]   rate_dividend;
    div_status_t            mean_st;
    div_status_t            rate_st;
    logic [DIV_DVD_W-1:0]   mean_q;
    logic [DIV_DSR_W-1:0]   mean_r;
    logic [DIV_DVD_W-1:0]   rate_q;
    logic [DIV_DSR_W-1:0]   rate_r;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Window arithmetic on the captured word
    assign bytes_sum  = {1'b0, bytes_reg} + {{(BYTES_W + 1 - LEN_W){1'b0}}, len_reg};
    assign elapsed    = time_reg - start_reg;
    assign sum_wide   = {{(TIME_W + 1 - SUM_W){1'b0}}, sum_reg} + {1'b0, interval_reg};
    assign checks_inc = (checks_reg == '1) ? checks_reg : checks_reg + 1'b1;
    assign gap        = (seq_reg != prev_seq_reg + 1'b1) && (checks_inc != COUNT_W'(1));

    // Launch both divisions together, then the second rate pass
    assign mean_start    = (state_reg == S_UPDATE) && rep_reg;
    assign rate_start    = mean_start || ((state_reg == S_DIV1) && rate_st.done);
    assign rate_dividend = (state_reg == S_UPDATE)
                         ? {{(DIV_DVD_W - BYTES_W - BYTE_SHIFT){1'b0}}, bytes_reg,
                            {BYTE_SHIFT{1'b0}}}
                         : rate_q;

    prsm_div u_mean_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mean_start),
        .dividend  (sum_reg),
        .divisor   (count_reg),
        .status    (mean_st),
        .quotient  (mean_q),
        .remainder (mean_r)
    );

    prsm_div u_rate_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rate_start),
        .dividend  (rate_dividend),
        .divisor   (DIV_DSR_W'(BITS_PER_KBIT)),
        .status    (rate_st),
        .quotient  (rate_q),
        .remainder (rate_r)
    );

    // Sequencer and datapath next values
    always_comb
    begin
        max_len_next    = max_len_reg;
        window_next     = window_reg;
        seq_en_next     = seq_en_reg;
        state_next      = state_reg;
        len_next        = len_reg;
        time_next       = time_reg;
        seq_next        = seq_reg;
        bytes_next      = bytes_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        start_next      = start_reg;
        last_next       = last_reg;
        prev_seq_next   = prev_seq_reg;
        checks_next     = checks_reg;
        gaps_next       = gaps_reg;
        interval_next   = interval_reg;
        over_next       = over_reg;
        rep_next        = rep_reg;
        serr_next       = serr_reg;
        mean_next       = mean_reg;
        mbps_next       = mbps_reg;
        kbps_next       = kbps_reg;
        out_valid_next  = out_valid_reg;
        out_over_next   = out_over_reg;
        out_rep_next    = out_rep_reg;
        out_mbps_next   = out_mbps_reg;
        out_kbps_next   = out_kbps_reg;
        out_mean_next   = out_mean_reg;
        out_serr_next   = out_serr_reg;
        out_gaps_next   = out_gaps_reg;
        out_checks_next = out_checks_reg;

        // Write configuration registers
        if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_MAX_LEN: max_len_next = cfg_data[LEN_W-1:0];
                CFG_WINDOW:  window_next  = cfg_data[WIN_W-1:0];
                CFG_SEQ_EN:  seq_en_next  = cfg_data[0];
                default:     ;
            endcase
        end

        // Drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    len_next   = packet_length;
                    time_next  = arrival_time_us;
                    seq_next   = seq_number;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                // Add bytes always, measure interval, classify the packet
                bytes_next    = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
                interval_next = time_reg - last_reg;
                over_next     = (len_reg > max_len_reg);
                rep_next      = !(len_reg > max_len_reg) &&
                                ({{(TIME_W - WIN_W){1'b0}}, window_reg} <= elapsed);
                serr_next     = 1'b0;
                state_next    = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (over_reg)
                begin
                    state_next = S_OUT;
                end
                else if (rep_reg)
                begin
                    state_next = S_DIV1;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV1:
            begin
                // Hold the mean; the rate divider restarts on kilobits
                if (rate_st.done)
                begin
                    mean_next  = (count_reg == '0) ? '0 : mean_q;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (rate_st.done)
                begin
                    mbps_next  = rate_q[MBPS_W-1:0];
                    kbps_next  = rate_r[KBPS_W-1:0];
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // Close the window or accumulate the interval
                if (rep_reg)
                begin
                    sum_next   = mean_reg;
                    count_next = COUNT_W'(1);
                    bytes_next = '0;
                    start_next = time_reg;
                end
                else
                begin
                    sum_next   = (sum_wide > {{(TIME_W + 1 - SUM_W){1'b0}}, {SUM_W{1'b1}}})
                               ? '1 : sum_wide[SUM_W-1:0];
                    count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
                end
                last_next = time_reg;
                // Check the sequence number against its predecessor
                if (seq_en_reg)
                begin
                    checks_next   = checks_inc;
                    prev_seq_next = seq_reg;
                    if (gap)
                    begin
                        gaps_next = (gaps_reg == '1) ? gaps_reg : gaps_reg + 1'b1;
                        serr_next = 1'b1;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Load the output register when it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_over_next   = over_reg;
                    out_rep_next    = rep_reg;
                    out_mbps_next   = rep_reg ? mbps_reg : '0;
                    out_kbps_next   = rep_reg ? kbps_reg : '0;
                    out_mean_next   = rep_reg ? mean_reg : '0;
                    out_serr_next   = serr_reg;
                    out_gaps_next   = gaps_reg;
                    out_checks_next = checks_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            window_reg    <= WINDOW_RESET;
            seq_en_reg    <= 1'b0;
            state_reg     <= S_IDLE;
            bytes_reg     <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            start_reg     <= '0;
            last_reg      <= '0;
            prev_seq_reg  <= '0;
            checks_reg    <= '0;
            gaps_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_len_reg   <= max_len_next;
            window_reg    <= window_next;
            seq_en_reg    <= seq_en_next;
            state_reg     <= state_next;
            bytes_reg     <= bytes_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            prev_seq_reg  <= prev_seq_next;
            checks_reg    <= checks_next;
            gaps_reg      <= gaps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        time_reg       <= time_next;
        seq_reg        <= seq_next;
        interval_reg   <= interval_next;
        over_reg       <= over_next;
        rep_reg        <= rep_next;
        serr_reg       <= serr_next;
        mean_reg       <= mean_next;
        mbps_reg       <= mbps_next;
        kbps_reg       <= kbps_next;
        out_over_reg   <= out_over_next;
        out_rep_reg    <= out_rep_next;
        out_mbps_reg   <= out_mbps_next;
        out_kbps_reg   <= out_kbps_next;
        out_mean_reg   <= out_mean_next;
        out_serr_reg   <= out_serr_next;
        out_gaps_reg   <= out_gaps_next;
        out_checks_reg <= out_checks_next;
    end

    assign out_valid          = out_valid_reg;
    assign oversize           = out_over_reg;
    assign report_valid       = out_rep_reg;
    assign rate_mbps          = out_mbps_reg;
    assign rate_kbps_fraction = out_kbps_reg;
    assign mean_interval_us   = out_mean_reg;
    assign seq_error          = out_serr_reg;
    assign error_count        = out_gaps_reg;
    assign check_count        = out_checks_reg;

`ifndef SYNTHESIS
    // Both dividers run in lockstep through the first pass
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV1) |-> (mean_st.done == rate_st.done))
        else $error("mean and rate dividers out of step");

    // A new output word comes only from the output state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output loaded outside output state");

    // An oversize packet reports nothing else
    a_oversize_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_over_reg) |-> (!out_rep_reg && !out_serr_reg))
        else $error("oversize packet reported rate or gap");

    // Rate fields are zero outside a report
    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_rep_reg) |->
        (out_mbps_reg == '0 && out_kbps_reg == '0 && out_mean_reg == '0))
        else $error("rate fields set without report");

    // An accepted word moves straight into calculation
    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_CALC))
        else $error("accepted word not processed");
`endif

endmodule

[hdl/prsm_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
module prsm_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [prsm_pkg::DIV_DVD_W-1:0]      dividend,
    input  logic [prsm_pkg::DIV_DSR_W-1:0]      divisor,
    output prsm_pkg::div_status_t               status,
    output logic [prsm_pkg::DIV_DVD_W-1:0]      quotient,
    output logic [prsm_pkg::DIV_DSR_W-1:0]      remainder
);
    import prsm_pkg::*;

    logic [DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_DSR_W-1:0] rem_reg, rem_next;
    logic [DIV_DSR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DSR_W:0]   shifted;
    logic [DIV_DSR_W+1:0] diff;
    logic                 neg;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[DIV_DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign neg     = diff[DIV_DSR_W+1];

    // Load on start, then shift one quotient bit in per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_DVD_W-2:0], ~neg};
            rem_next = neg ? shifted[DIV_DSR_W-1:0] : diff[DIV_DSR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

`ifndef SYNTHESIS
    // Start never lands on a division in progress
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Done follows the last busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a division");

    // Done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
`endif

endmodule

[test/tb_top.sv]
// Self-checking testbench for the packet rate and sequence monitor.
`timescale 1ns / 1ps

module tb_top;
    import prsm_pkg::*;

    localparam int          NUM_PHASES      = 8;
    localparam int          WORDS_PER_PHASE = 242;
    localparam int          DRAIN_CYCLES    = 120;
    localparam int unsigned CYCLE_LIMIT     = 2000000;
    localparam logic [31:0] MICROS_PER_SEC  = 32'd1000000;
    localparam logic [31:0] BITS_PER_KB     = 32'd1000;
    localparam logic [SUM_W-1:0]   SUM_TOP   = '1;
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    // One result word, in port order
    typedef struct packed {
        logic               over;
        logic               rep;
        logic [MBPS_W-1:0]  mbps;
        logic [KBPS_W-1:0]  kbps;
        logic [SUM_W-1:0]   mean;
        logic               serr;
        logic [COUNT_W-1:0] gaps;
        logic [COUNT_W-1:0] checks;
    } rate_result_t;

    typedef enum logic { ROW_PKT, ROW_CFG } row_kind_t;
    typedef enum logic [1:0] { STALL_NONE, STALL_RANDOM, STALL_LONG } stall_mode_t;

    // A directed row: a register write or a packet, with an optional fixed result
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [LEN_W-1:0]      len;
        logic [TIME_W-1:0]     arrival;
        logic [SEQ_W-1:0]      seq;
        logic                  fixed;
        rate_result_t          result;
    } directed_row_t;

    localparam rate_result_t QUIET = '0;
    localparam int NUM_DIRECTED = 22;

    // Packet rows name CFG_MAX_LEN only as a filler index
    localparam directed_row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
        // Defaults after reset: a quiet packet, a packet at the length limit
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd100, 48'd10, 16'd0, 1'b1, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'hFFFF, 48'd20, 16'hFFFF, 1'b1, QUIET},
        // First window closes exactly at one second: 65635 bytes, mean of 10 us
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd0, 48'd1000000, 16'd1, 1'b1,
          '{1'b0, 1'b1, 16'd0, 10'd525, 40'd10, 1'b0, 32'd0, 32'd0}},
        // Zero length limit: one byte is oversize, an empty packet passes
        '{ROW_CFG, CFG_MAX_LEN, 32'd0, 16'd0, 48'd0, 16'd0, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd1, 48'd1000050, 16'd2, 1'b1,
          '{1'b1, 1'b0, 16'd0, 10'd0, 40'd0, 1'b0, 32'd0, 32'd0}},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd0, 48'd1000100, 16'd3, 1'b0, QUIET},
        // Length limit 1500, sequence checking on, zero window so every packet reports
        '{ROW_CFG, CFG_MAX_LEN, 32'd1500, 16'd0, 48'd0, 16'd0, 1'b0, QUIET},
        '{ROW_CFG, CFG_SEQ_EN, 32'd1, 16'd0, 48'd0, 16'd0, 1'b0, QUIET},
        '{ROW_CFG, CFG_WINDOW, 32'd0, 16'd0, 48'd0, 16'd0, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd1500, 48'd1000200, 16'hFFFF, 1'b0, QUIET},
        // Oversize with checking on: totals shown, nothing counted
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd1501, 48'd1000300, 16'd7, 1'b1,
          '{1'b1, 1'b0, 16'd0, 10'd0, 40'd0, 1'b0, 32'd0, 32'd1}},
        // Wrap to zero, a jump, a repeat, then time wrapping around
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd64, 48'd1000300, 16'd0, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd64, 48'd1000400, 16'd5, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd64, 48'd1000500, 16'd5, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd64, 48'hFFFF_FFFF_FFFF, 16'd6, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd64, 48'd3, 16'd7, 1'b0, QUIET},
        // Longest window; a step back in time saturates the interval sum
        '{ROW_CFG, CFG_WINDOW, 32'hFFFF_FFFF, 16'd0, 48'd0, 16'd0, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd1500, 48'h8000_0000_0000, 16'd8, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd1500, 48'h8000_0000_1000, 16'd9, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd1500, 48'h8000_0000_0FF0, 16'd10, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd1500, 48'h8000_0000_2000, 16'd11, 1'b0, QUIET},
        '{ROW_PKT, CFG_MAX_LEN, 32'd0, 16'd1500, 48'h8001_0000_0000, 16'd12, 1'b0, QUIET}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_enable = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAX_LEN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [LEN_W-1:0]      packet_length = '0;
    logic [TIME_W-1:0]     arrival_time_us = '0;
    logic [SEQ_W-1:0]      seq_number = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  oversize;
    logic                  report_valid;
    logic [MBPS_W-1:0]     rate_mbps;
    logic [KBPS_W-1:0]     rate_kbps_fraction;
    logic [SUM_W-1:0]      mean_interval_us;
    logic                  seq_error;
    logic [COUNT_W-1:0]    error_count;
    logic [COUNT_W-1:0]    check_count;

    // Predictor copy of the registers
    logic [LEN_W-1:0]      max_len_reg;
    logic [WIN_W-1:0]      window_reg;
    logic                  seq_check_reg;

    // Predictor copy of the running totals
    logic [BYTES_W-1:0]    byte_total;
    logic [SUM_W-1:0]      gap_time_sum;
    logic [COUNT_W-1:0]    gap_time_count;
    logic [TIME_W-1:0]     window_open_time;
    logic [TIME_W-1:0]     last_seen_time;
    logic [SEQ_W-1:0]      last_seq;
    logic [COUNT_W-1:0]    seq_checks;
    logic [COUNT_W-1:0]    seq_gaps;

    rate_result_t          pending_results[$];
    rate_result_t          oldest;
    int                    mismatch_count = 0;
    int unsigned           cycle_count = 0;
    stall_mode_t           stall_mode = STALL_RANDOM;
    int                    stall_run = 0;
    bit                    sender_gaps_on = 1'b1;
    int                    burst_left = 0;

    packet_rate_and_sequence_monitor u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_enable   (cfg_write_enable),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .packet_length      (packet_length),
        .arrival_time_us    (arrival_time_us),
        .seq_number         (seq_number),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .oversize           (oversize),
        .report_valid       (report_valid),
        .rate_mbps          (rate_mbps),
        .rate_kbps_fraction (rate_kbps_fraction),
        .mean_interval_us   (mean_interval_us),
        .seq_error          (seq_error),
        .error_count        (error_count),
        .check_count        (check_count)
    );

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Work out the result of one accepted packet and advance the totals
    function automatic rate_result_t predict_packet(input logic [LEN_W-1:0] len,
                                                    input logic [TIME_W-1:0] t,
                                                    input logic [SEQ_W-1:0] seq);
        rate_result_t       r;
        logic [BYTES_W:0]   byte_sum;
        logic [TIME_W:0]    time_sum;
        logic [TIME_W-1:0]  gap_time;
        logic [TIME_W-1:0]  elapsed;
        logic [BYTES_W+2:0] bits;
        logic [SEQ_W-1:0]   next_seq;
        r = '0;
        // Bytes count even when the packet turns out oversize
        byte_sum   = {1'b0, byte_total} + {17'd0, len};
        byte_total = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
        gap_time   = t - last_seen_time;
        elapsed    = t - window_open_time;
        if (len > max_len_reg)
        begin
            r.over = 1'b1;
        end
        else
        begin
            // Close the window: report rate and mean, restart from this packet
            if ({16'd0, window_reg} <= elapsed)
            begin
                bits             = {byte_total, 3'b000};
                r.rep            = 1'b1;
                r.mean           = (gap_time_count != 0) ? gap_time_sum / gap_time_count : '0;
                gap_time_sum     = r.mean;
                gap_time_count   = '0;
                r.mbps           = MBPS_W'(bits / MICROS_PER_SEC);
                r.kbps           = KBPS_W'((bits % MICROS_PER_SEC) / BITS_PER_KB);
                byte_total       = '0;
                window_open_time = t;
                gap_time         = '0;
            end
            time_sum       = {9'd0, gap_time_sum} + {1'b0, gap_time};
            gap_time_sum   = (time_sum > {9'd0, SUM_TOP}) ? SUM_TOP : time_sum[SUM_W-1:0];
            gap_time_count = (gap_time_count == COUNT_TOP) ? COUNT_TOP : gap_time_count + 1;
            last_seen_time = t;
            // Sequence check; the first checked packet is never a gap
            if (seq_check_reg)
            begin
                seq_checks = (seq_checks == COUNT_TOP) ? COUNT_TOP : seq_checks + 1;
                next_seq   = last_seq + 16'd1;
                if (seq != next_seq && seq_checks > 1)
                begin
                    seq_gaps = (seq_gaps == COUNT_TOP) ? COUNT_TOP : seq_gaps + 1;
                    r.serr   = 1'b1;
                end
                last_seq = seq;
            end
        end
        r.gaps   = seq_gaps;
        r.checks = seq_checks;
        return r;
    endfunction

    // Write one register once every result is out
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= index;
        cfg_data         <= value;
        case (index)
            CFG_MAX_LEN: max_len_reg   = value[LEN_W-1:0];
            CFG_WINDOW:  window_reg    = value[WIN_W-1:0];
            CFG_SEQ_EN:  seq_check_reg = value[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one packet word, in bursts with random gaps, and queue its result
    task automatic send_packet(input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] t,
                               input logic [SEQ_W-1:0] seq, input logic fixed,
                               input rate_result_t fixed_result);
        rate_result_t predicted;
        int           gap;
        if (burst_left == 0)
        begin
            gap = sender_gaps_on ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left      = burst_left - 1;
        in_valid        <= 1'b1;
        packet_length   <= len;
        arrival_time_us <= t;
        seq_number      <= seq;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_packet(len, t, seq);
        pending_results.push_back(fixed ? fixed_result : predicted);
    endtask

    // Receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (stall_run != 0)
                    begin
                        stall_run <= stall_run - 1;
                    end
                    else
                    begin
                        out_stall <= !out_stall;
                        stall_run <= out_stall ? $urandom_range(1, 20) : $urandom_range(0, 60);
                    end
                end
            endcase
        end
    end

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                $display("%0t: result word with none expected", $time);
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("oversize", 64'(oversize), 64'(oldest.over));
                check_field("report_valid", 64'(report_valid), 64'(oldest.rep));
                check_field("rate_mbps", 64'(rate_mbps), 64'(oldest.mbps));
                check_field("rate_kbps_fraction", 64'(rate_kbps_fraction),
                            64'(oldest.kbps));
                check_field("mean_interval_us", 64'(mean_interval_us), 64'(oldest.mean));
                check_field("seq_error", 64'(seq_error), 64'(oldest.serr));
                check_field("error_count", 64'(error_count), 64'(oldest.gaps));
                check_field("check_count", 64'(check_count), 64'(oldest.checks));
            end
        end
    end

    initial
    begin
        int                phase;
        int                n;
        int                sel;
        logic [LEN_W-1:0]  len_limit;
        logic [LEN_W-1:0]  len;
        logic [WIN_W-1:0]  win;
        logic [31:0]       reach;
        logic [TIME_W-1:0] stim_time;
        logic [SEQ_W-1:0]  stim_seq;

        max_len_reg      = MAX_LEN_RESET;
        window_reg       = WINDOW_RESET;
        seq_check_reg    = 1'b0;
        byte_total       = '0;
        gap_time_sum     = '0;
        gap_time_count   = '0;
        window_open_time = '0;
        last_seen_time   = '0;
        last_seq         = '0;
        seq_checks       = '0;
        seq_gaps         = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (n = 0; n < NUM_DIRECTED; n++)
        begin
            if (DIRECTED_ROWS[n].kind == ROW_CFG)
                write_register(DIRECTED_ROWS[n].reg_index, DIRECTED_ROWS[n].reg_value);
            else
                send_packet(DIRECTED_ROWS[n].len, DIRECTED_ROWS[n].arrival,
                            DIRECTED_ROWS[n].seq, DIRECTED_ROWS[n].fixed,
                            DIRECTED_ROWS[n].result);
        end

        stim_time = 48'd2000000;
        stim_seq  = 16'd0;

        // Random phases, each with its own register setting and idle pattern
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase % 4)
                0:       len_limit = 16'hFFFF;
                1:       len_limit = 16'd0;
                2:       len_limit = 16'd1500;
                default: len_limit = LEN_W'($urandom_range(0, 65535));
            endcase
            case (phase)
                0:       win = 32'd1;
                1:       win = 32'hFFFF_FFFF;
                2:       win = 32'd1000000;
                3:       win = $urandom_range(100, 5000);
                4:       win = $urandom;
                5:       win = 32'd0;
                6:       win = $urandom_range(1, 200);
                default: win = $urandom_range(1000, 100000);
            endcase
            write_register(CFG_MAX_LEN, {16'd0, len_limit});
            write_register(CFG_WINDOW, win);
            write_register(CFG_SEQ_EN, (phase % 3 != 2) ? 32'd1 : 32'd0);
            case (phase % 3)
                0:       stall_mode <= STALL_NONE;
                1:       stall_mode <= STALL_RANDOM;
                default: stall_mode <= STALL_LONG;
            endcase
            sender_gaps_on = (phase % 4 != 1);
            reach = (win >> 2) + 1;

            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Length: mostly within the limit, sometimes anything
                sel = $urandom_range(0, 3);
                case (sel)
                    0:       len = LEN_W'($urandom_range(0, 65535));
                    1:       len = len_limit;
                    default: len = LEN_W'($urandom_range(0, len_limit));
                endcase
                // Arrival: mostly forward steps scaled to the window
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    stim_time = stim_time;
                else if (sel <= 12)
                    stim_time = stim_time + TIME_W'($urandom_range(0, reach));
                else if (sel <= 16)
                    stim_time = stim_time + TIME_W'($urandom_range(0, 2000));
                else if (sel <= 18)
                    stim_time = stim_time - TIME_W'($urandom_range(0, 5000));
                else
                    stim_time = TIME_W'({$urandom, $urandom});
                // Sequence: mostly in order, with repeats, wraps and jumps
                sel = $urandom_range(0, 19);
                if (sel < 16)
                    stim_seq = stim_seq + 16'd1;
                else if (sel == 17)
                    stim_seq = 16'hFFFF;
                else if (sel == 18)
                    stim_seq = 16'd0;
                else if (sel == 19)
                    stim_seq = SEQ_W'($urandom_range(0, 65535));
                send_packet(len, stim_time, stim_seq, 1'b0, QUIET);
            end
        end

        // Drain, then watch for stray words
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
